// File: rtl/btpe_pkg.sv
// btpe_pkg: beat types, sequencer states and packet codes for the
// branch trace packet encoder. no dependencies.
package btpe_pkg;

  typedef struct packed {
    logic [2:0]  entry_kind;
    logic [63:0] entry_address;
    logic [63:0] entry_time;
  } entry_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } packet_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_HEAD,
    ST_VAR1,
    ST_VAR2
  } state_t;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_TAKEN    = 3'd1;
  localparam logic [2:0] KIND_NOTTAKEN = 3'd2;
  localparam logic [2:0] KIND_INFJUMP  = 3'd3;
  localparam logic [2:0] KIND_UNINFJMP = 3'd4;
  localparam logic [2:0] KIND_EXCEPT   = 3'd5;

  localparam logic [1:0] CH_TB = 2'd0;
  localparam logic [1:0] CH_NT = 2'd1;
  localparam logic [1:0] CH_NA = 2'd2;
  localparam logic [1:0] CH_IJ = 2'd3;

  localparam logic [2:0] FH_TB   = 3'd0;
  localparam logic [2:0] FH_NT   = 3'd1;
  localparam logic [2:0] FH_UJ   = 3'd2;
  localparam logic [2:0] FH_IJ   = 3'd3;
  localparam logic [2:0] FH_TRAP = 3'd4;
  localparam logic [2:0] FH_SYNC = 3'd5;

  localparam logic [2:0] TRAP_NONE = 3'd0;

  localparam int unsigned VARINT_BITS = 7;

endpackage

// File: rtl/btpe_varint.sv
// btpe_varint: shift register that splits a 64-bit value into 7-bit varint
// digits, one digit a cycle while shift is high. uses btpe_pkg.
module btpe_varint
  import btpe_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [63:0] load_value,
  input  logic        shift,
  output logic [6:0]  digit,
  output logic        done
);

  logic [63:0] work;

  always_ff @(posedge clk) begin
    if (load) begin
      work <= load_value;
    end else if (shift) begin
      work <= work >> VARINT_BITS;
    end
  end

  assign digit = work[6:0];
  assign done  = (work >> VARINT_BITS) == 64'd0;

endmodule

// File: rtl/branch_trace_packet_encoder.sv
// branch_trace_packet_encoder: turns retired-instruction records into trace
// bytes (sync, branch and addressed packets). uses btpe_pkg and btpe_varint.
//
//   channel  | handshake              | beat
//   entry    | entry_valid/entry_stall| one record: kind, address, time
//   packet   | packet_valid/stall     | one trace byte with last mark
//   cfg      | cfg_valid/cfg_ready    | trace_enable bit
//
// a record is captured and then planned; after that one trace byte per cycle
// goes out through the shared varint shifter while the output is free. a
// record may send no byte, and a packet has up to twenty bytes. entry_stall
// is high from capture until the last byte sits in the output register. rst
// is synchronous and clears the sequencer, mode, held record and enable.
// packet_stall holds the output register and the sequencer waits on it.
module branch_trace_packet_encoder
  import btpe_pkg::*;
#(
  parameter int unsigned COMPRESS_LIMIT = 6,
  parameter int unsigned TIME_WIDTH     = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  entry_t  entry,
  input  logic    entry_valid,
  output logic    entry_stall,
  output packet_t packet,
  output logic    packet_valid,
  input  logic    packet_stall,
  input  logic    cfg_data,
  input  logic    cfg_valid,
  output logic    cfg_ready
);

  state_t state, state_next;

  logic                  trace_enable;
  logic                  trace_mode;
  logic [2:0]            held_kind;
  logic [63:0]           held_address;
  logic [TIME_WIDTH-1:0] held_time;
  logic [TIME_WIDTH-1:0] emitted_time;

  logic [2:0]            cur_kind;
  logic [63:0]           cur_address;
  logic [TIME_WIDTH-1:0] cur_time;

  logic [7:0]  head_byte;
  logic        head_last;
  logic        has_var1;
  logic [63:0] pend;

  // plan signals
  logic [TIME_WIDTH-1:0] delta;
  logic        do_sync, do_data, is_direct, fits_short;
  logic [1:0]  ch;
  logic [2:0]  fh, trap;
  logic [7:0]  head_byte_next;
  logic        head_last_next, has_var1_next;
  logic [63:0] var1_value, pend_next;

  // control
  logic        accept, out_free, emit;
  logic        vl_load, vl_shift;
  logic [63:0] vl_value;
  logic [6:0]  digit;
  logic        vdone;
  packet_t     packet_next;

  assign accept   = entry_valid && !entry_stall;
  assign out_free = !packet_valid || !packet_stall;
  assign cfg_ready = 1'b1;

  btpe_varint u_varint (
    .clk        (clk),
    .load       (vl_load),
    .load_value (vl_value),
    .shift      (vl_shift),
    .digit      (digit),
    .done       (vdone)
  );

  // packet planning from the captured and held records
  always_comb begin
    delta      = held_time - emitted_time;
    do_sync    = trace_enable ? !trace_mode : trace_mode;
    do_data    = trace_enable && trace_mode && (held_kind != KIND_NONE);
    is_direct  = (held_kind == KIND_TAKEN) || (held_kind == KIND_NOTTAKEN) ||
                 (held_kind == KIND_INFJUMP);
    fits_short = (delta >> COMPRESS_LIMIT) == '0;
    ch   = CH_TB;
    fh   = FH_TB;
    trap = TRAP_NONE;
    case (held_kind)
      KIND_TAKEN: begin
        ch = CH_TB;
        fh = FH_TB;
      end
      KIND_NOTTAKEN: begin
        ch = CH_NT;
        fh = FH_NT;
      end
      KIND_INFJUMP: begin
        ch = CH_IJ;
        fh = FH_IJ;
      end
      KIND_UNINFJMP: begin
        fh = FH_UJ;
      end
      default: begin
        fh   = FH_TRAP;
        trap = held_kind - KIND_UNINFJMP;
      end
    endcase

    head_last_next = 1'b0;
    has_var1_next  = 1'b1;
    var1_value     = {1'b0, cur_address[63:1] ^ held_address[63:1]};
    pend_next      = 64'(delta);
    head_byte_next = {trap, fh, CH_NA};
    if (do_sync) begin
      head_byte_next = {TRAP_NONE, FH_SYNC, CH_NA};
      var1_value     = {1'b0, cur_address[63:1]};
      pend_next      = 64'(cur_time);
    end else if (is_direct) begin
      has_var1_next = 1'b0;
      if (fits_short) begin
        head_byte_next = {delta[5:0], ch};
        head_last_next = 1'b1;
      end else begin
        head_byte_next = {TRAP_NONE, fh, CH_NA};
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_next = (do_sync || do_data) ? ST_HEAD : ST_IDLE;
      end
      ST_HEAD: begin
        if (out_free) begin
          if (head_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = has_var1 ? ST_VAR1 : ST_VAR2;
          end
        end
      end
      ST_VAR1: begin
        if (out_free && vdone) begin
          state_next = ST_VAR2;
        end
      end
      ST_VAR2: begin
        if (out_free && vdone) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    entry_stall = (state != ST_IDLE);
    emit        = 1'b0;
    vl_load     = 1'b0;
    vl_shift    = 1'b0;
    vl_value    = pend;
    packet_next = '{out_byte: head_byte, last_byte: head_last};
    case (state)
      ST_PLAN: begin
        vl_load  = 1'b1;
        vl_value = has_var1_next ? var1_value : pend_next;
      end
      ST_HEAD: begin
        emit = out_free;
      end
      ST_VAR1: begin
        emit        = out_free;
        vl_load     = out_free && vdone;
        vl_shift    = out_free;
        packet_next = '{out_byte: {vdone, digit}, last_byte: 1'b0};
      end
      ST_VAR2: begin
        emit        = out_free;
        vl_shift    = out_free;
        packet_next = '{out_byte: {vdone, digit}, last_byte: vdone};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      trace_enable <= 1'b0;
      trace_mode   <= 1'b0;
      held_kind    <= KIND_NONE;
      held_address <= '0;
      held_time    <= '0;
      packet_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        trace_enable <= cfg_data;
      end
      if (state == ST_PLAN) begin
        if (do_sync) begin
          trace_mode <= trace_enable;
        end
        held_kind    <= cur_kind;
        held_address <= cur_address;
        held_time    <= cur_time;
      end
      if (emit) begin
        packet_valid <= 1'b1;
      end else if (!packet_stall) begin
        packet_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind    <= entry.entry_kind;
      cur_address <= entry.entry_address;
      cur_time    <= entry.entry_time[TIME_WIDTH-1:0];
    end
    if (state == ST_PLAN) begin
      head_byte <= head_byte_next;
      head_last <= head_last_next;
      has_var1  <= has_var1_next;
      pend      <= pend_next;
      if (do_sync) begin
        emitted_time <= cur_time;
      end else if (do_data) begin
        emitted_time <= held_time;
      end
    end
    if (emit) begin
      packet <= packet_next;
    end
  end

endmodule
